[src/usvg_pkg.sv]
// ----------------------------------------------------------------------------
// usvg_pkg: shared types and constants of the UV sphere vertex generator
// Fixed-point formats, pipeline payload structs and rounding helpers.
// ----------------------------------------------------------------------------
package usvg_pkg;

  localparam int unsigned FRAC_BITS  = 14;
  localparam int unsigned INNER_BITS = 30;
  localparam int unsigned SH1        = INNER_BITS - FRAC_BITS;
  localparam int unsigned SH2        = 2 * INNER_BITS - FRAC_BITS;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned PHI_STEPS  = 31;
  localparam int unsigned TEX_STEPS  = FRAC_BITS;

  localparam int unsigned CNT_W  = 9;
  localparam int unsigned IDX_W  = 17;
  localparam int unsigned TEX_W  = 15;
  localparam int unsigned OUT_W  = 16;
  localparam int unsigned CORD_W = 33;

  // register indexes on the cfg port
  localparam logic CFG_SLICES = 1'b0;
  localparam logic CFG_STACKS = 1'b1;

  localparam logic signed [CORD_W-1:0] GAIN_Q30 = 33'sd652032874;
  localparam logic signed [OUT_W+1:0]  UNIT_POS = 18'sd16384;
  localparam logic signed [OUT_W+1:0]  UNIT_NEG = -18'sd16384;

  // arctangent of 2^-i in binary-angle units (2^32 per turn)
  localparam logic [29:0] ATAN_BAU [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10680862, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic [IDX_W-1:0] below_index;
    logic             quad_corner;
    logic             out_of_range;
  } meta_t;

  typedef struct packed {
    logic             valid;
    meta_t            meta;
    logic [CNT_W-1:0] rem_t;
    logic [CNT_W-1:0] rem_p;
    logic [CNT_W-1:0] rem_u;
    logic [CNT_W-1:0] rem_v;
    logic [31:0]      q_t;
    logic [31:0]      q_p;
    logic [TEX_W-1:0] q_u;
    logic [TEX_W-1:0] q_v;
  } div_t;

  typedef struct packed {
    logic                     valid;
    meta_t                    meta;
    logic [1:0]               quad_t;
    logic [1:0]               quad_p;
    logic signed [CORD_W-1:0] x_t;
    logic signed [CORD_W-1:0] y_t;
    logic signed [CORD_W-1:0] z_t;
    logic signed [CORD_W-1:0] x_p;
    logic signed [CORD_W-1:0] y_p;
    logic signed [CORD_W-1:0] z_p;
    logic [TEX_W-1:0]         tex_u;
    logic [TEX_W-1:0]         tex_v;
  } cord_t;

  // Q2.30 -> Q1.14, round half up, saturate to +-1.0
  function automatic logic [OUT_W-1:0] fix_q30(input logic signed [CORD_W:0] v);
    logic signed [CORD_W:0]  t;
    logic signed [OUT_W+1:0] r;
    t = (v + (34'sd1 <<< (SH1 - 1))) >>> SH1;
    r = t[OUT_W+1:0];
    if (t > 34'(UNIT_POS)) r = UNIT_POS;
    else if (t < 34'(UNIT_NEG)) r = UNIT_NEG;
    return r[OUT_W-1:0];
  endfunction

  // Q4.60 product -> Q1.14
  function automatic logic [OUT_W-1:0] fix_q60(input logic signed [63:0] p);
    logic signed [63:0]      t;
    logic signed [OUT_W+1:0] r;
    t = (p + (64'sd1 <<< (SH2 - 1))) >>> SH2;
    r = t[OUT_W+1:0];
    if (t > 64'(UNIT_POS)) r = UNIT_POS;
    else if (t < 64'(UNIT_NEG)) r = UNIT_NEG;
    return r[OUT_W-1:0];
  endfunction

endpackage

[src/usvg_div_cell.sv]
// ----------------------------------------------------------------------------
// usvg_div_cell: one restoring-division step for each quotient lane its STEP covers
// Lanes: theta angle, phi angle, texture u and texture v.
// ----------------------------------------------------------------------------
module usvg_div_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [usvg_pkg::CNT_W-1:0] slice_i,
  input  logic [usvg_pkg::CNT_W-1:0] stack_i,
  input  usvg_pkg::div_t            d_i,
  output usvg_pkg::div_t            q_o
);

  localparam int unsigned TB = (STEP < usvg_pkg::TEX_STEPS) ? usvg_pkg::TEX_STEPS - 1 - STEP : 0;

  usvg_pkg::div_t nxt, pay_q;
  logic           vld_q;
  logic [13:0]    half_s, half_t;

  function automatic logic [9:0] dstep(input logic [8:0] r, input logic b,
                                       input logic [8:0] d);
    logic [9:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) return {1'b1, 9'(t - {1'b0, d})};
    return {1'b0, t[8:0]};
  endfunction

  assign half_s = 14'(slice_i >> 1);
  assign half_t = 14'(stack_i >> 1);

  always_comb begin
    logic [9:0] s;
    nxt = d_i;
    s = dstep(d_i.rem_t, 1'b0, slice_i);
    nxt.rem_t = s[8:0];
    nxt.q_t   = {d_i.q_t[30:0], s[9]};
    if (STEP < usvg_pkg::PHI_STEPS) begin
      s = dstep(d_i.rem_p, 1'b0, stack_i);
      nxt.rem_p = s[8:0];
      nxt.q_p   = {d_i.q_p[30:0], s[9]};
    end
    if (STEP < usvg_pkg::TEX_STEPS) begin
      s = dstep(d_i.rem_u, half_s[TB], slice_i);
      nxt.rem_u = s[8:0];
      nxt.q_u   = {d_i.q_u[13:0], s[9]};
      s = dstep(d_i.rem_v, half_t[TB], stack_i);
      nxt.rem_v = s[8:0];
      nxt.q_v   = {d_i.q_v[13:0], s[9]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (en_i) vld_q <= d_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) pay_q <= nxt;
  end

  always_comb begin
    q_o       = pay_q;
    q_o.valid = vld_q;
  end

endmodule

[src/usvg_cordic_cell.sv]
// ----------------------------------------------------------------------------
// usvg_cordic_cell: one rotation-mode CORDIC iteration on both angle lanes
// Floor shifts, arctangent constant fixed by the cell's position.
// ----------------------------------------------------------------------------
module usvg_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  usvg_pkg::cord_t d_i,
  output usvg_pkg::cord_t q_o
);

  localparam logic signed [usvg_pkg::CORD_W-1:0] ATAN =
    $signed({3'b000, usvg_pkg::ATAN_BAU[STEP]});

  usvg_pkg::cord_t nxt, pay_q;
  logic            vld_q;

  always_comb begin
    nxt = d_i;
    if (!d_i.z_t[usvg_pkg::CORD_W-1]) begin
      nxt.x_t = d_i.x_t - (d_i.y_t >>> STEP);
      nxt.y_t = d_i.y_t + (d_i.x_t >>> STEP);
      nxt.z_t = d_i.z_t - ATAN;
    end else begin
      nxt.x_t = d_i.x_t + (d_i.y_t >>> STEP);
      nxt.y_t = d_i.y_t - (d_i.x_t >>> STEP);
      nxt.z_t = d_i.z_t + ATAN;
    end
    if (!d_i.z_p[usvg_pkg::CORD_W-1]) begin
      nxt.x_p = d_i.x_p - (d_i.y_p >>> STEP);
      nxt.y_p = d_i.y_p + (d_i.x_p >>> STEP);
      nxt.z_p = d_i.z_p - ATAN;
    end else begin
      nxt.x_p = d_i.x_p + (d_i.y_p >>> STEP);
      nxt.y_p = d_i.y_p - (d_i.x_p >>> STEP);
      nxt.z_p = d_i.z_p + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (en_i) vld_q <= d_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) pay_q <= nxt;
  end

  always_comb begin
    q_o       = pay_q;
    q_o.valid = vld_q;
  end

endmodule

[src/usvg_out_stage.sv]
// ----------------------------------------------------------------------------
// usvg_out_stage: quadrant fold, products and rounding to Q1.14
// Two registered stages; the second one is the output register.
// ----------------------------------------------------------------------------
module usvg_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  usvg_pkg::cord_t d_i,
  output logic            valid_o,
  output logic [151:0]    data_o
);

  localparam int unsigned CW = usvg_pkg::CORD_W;

  logic                 a_vld_q, b_vld_q;
  usvg_pkg::meta_t      a_meta_q;
  logic signed [63:0]   px_q, pz_q;
  logic signed [CW-1:0] cp_q, ct_q, st_q;
  logic [usvg_pkg::TEX_W-1:0] u_q, v_q;
  logic signed [CW-1:0] ct, st, cp, sp;
  logic [151:0]         data_d, data_q;

  function automatic logic [2*CW-1:0] fold(input logic [1:0] q,
                                           input logic signed [CW-1:0] x,
                                           input logic signed [CW-1:0] y);
    case (q)
      2'd0:    return {x, y};
      2'd1:    return {-y, x};
      2'd2:    return {-x, -y};
      default: return {y, -x};
    endcase
  endfunction

  always_comb begin
    {ct, st} = fold(d_i.quad_t, d_i.x_t, d_i.y_t);
    {cp, sp} = fold(d_i.quad_p, d_i.x_p, d_i.y_p);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= d_i.valid;
      b_vld_q <= a_vld_q;
    end
  end

  // magnitudes stay near 2^30, so 32-bit operands are exact
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_meta_q <= d_i.meta;
      px_q     <= $signed(sp[31:0]) * $signed(ct[31:0]);
      pz_q     <= $signed(sp[31:0]) * $signed(st[31:0]);
      cp_q     <= cp;
      ct_q     <= ct;
      st_q     <= st;
      u_q      <= d_i.tex_u;
      v_q      <= d_i.tex_v;
      data_q   <= data_d;
    end
  end

  always_comb begin
    data_d = '0;
    if (a_meta_q.out_of_range) begin
      data_d[145] = 1'b1;
    end else begin
      data_d[15:0]    = usvg_pkg::fix_q60(px_q);
      data_d[31:16]   = usvg_pkg::fix_q30(34'(cp_q));
      data_d[47:32]   = usvg_pkg::fix_q60(pz_q);
      data_d[62:48]   = u_q;
      data_d[77:63]   = v_q;
      data_d[93:78]   = usvg_pkg::fix_q30(-34'(st_q));
      data_d[109:94]  = usvg_pkg::fix_q30(34'(ct_q));
      data_d[126:110] = a_meta_q.vertex_index;
      data_d[143:127] = a_meta_q.below_index;
      data_d[144]     = a_meta_q.quad_corner;
    end
  end

  assign valid_o = b_vld_q;
  assign data_o  = data_q;

endmodule

[src/uv_sphere_vertex_generator_top.sv]
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_top: UV sphere vertex generator
// Grid point in, position/normal, texture, tangent and mesh indices out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one grid point per request (column, row). m_axis returns
//   one vertex per request, in order. slice_count and stack_count are set on
//   the cfg port (index 0 and 1) while no request is in flight, a rule for
//   the user, not enforced by the block; out-of-range values are clamped.
//   The datapath is a chain of cells: 32 long-division cells form the two
//   angles and the texture coordinates, then CORDIC_STEPS CORDIC cells take
//   sine and cosine, then a product stage and the output register.
//   The chain takes one request per cycle while it is not held.
//   The whole chain advances together; it holds when the output register is
//   full and m_axis_tready is low, and s_axis_tready drops then. A request is
//   still taken while a bubble sits in the output register.
//   Reset clears all valid flags and loads the counts 64 and 32.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_top #(
  parameter int unsigned MAX_SLICES   = 256,
  parameter int unsigned MAX_STACKS   = 256,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [8:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // column[8:0], row[17:9]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, tan_x, tan_z, vertex_index,
  // below_index, quad_corner, out_of_range
  output logic [151:0] m_axis_tdata
);

  logic [8:0] slice_q, stack_q, cfg_s, cfg_t;
  logic       en;
  logic [8:0] col, row;
  logic [18:0] vi;
  usvg_pkg::div_t  div_in;
  usvg_pkg::div_t  div_c  [usvg_pkg::DIV_STEPS];
  usvg_pkg::cord_t cord_in;
  usvg_pkg::cord_t cord_c [CORDIC_STEPS];

  always_comb begin
    cfg_s = cfg_wdata_i;
    if (cfg_wdata_i < 9'd3) cfg_s = 9'd3;
    else if (32'(cfg_wdata_i) > MAX_SLICES) cfg_s = 9'(MAX_SLICES);
    cfg_t = cfg_wdata_i;
    if (cfg_wdata_i < 9'd2) cfg_t = 9'd2;
    else if (32'(cfg_wdata_i) > MAX_STACKS) cfg_t = 9'(MAX_STACKS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= 9'd64;
      stack_q <= 9'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        usvg_pkg::CFG_SLICES: slice_q <= cfg_s;
        usvg_pkg::CFG_STACKS: stack_q <= cfg_t;
        default:    ;
      endcase
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign col = s_axis_tdata[8:0];
  assign row = s_axis_tdata[17:9];
  assign vi  = 19'(row) * (19'(slice_q) + 19'd1) + 19'(col);

  // a full count loads a zero remainder and carries the quotient's top bit, except in the theta lane
  always_comb begin
    div_in       = '0;
    div_in.valid = s_axis_tvalid;
    div_in.meta.out_of_range = (col > slice_q) || (row > stack_q);
    if (!div_in.meta.out_of_range) begin
      div_in.meta.vertex_index = vi[16:0];
      div_in.meta.below_index  = 17'(vi + 19'(slice_q) + 19'd1);
      div_in.meta.quad_corner  = (col < slice_q) && (row < stack_q);
    end
    div_in.rem_t = (col == slice_q) ? '0 : col;
    div_in.rem_u = div_in.rem_t;
    div_in.q_u   = 15'(col == slice_q);
    div_in.rem_p = (row == stack_q) ? '0 : row;
    div_in.rem_v = div_in.rem_p;
    div_in.q_p   = 32'(row == stack_q);
    div_in.q_v   = 15'(row == stack_q);
  end

  for (genvar i = 0; i < usvg_pkg::DIV_STEPS; i++) begin : g_div
    usvg_div_cell #(.STEP(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .slice_i (slice_q),
      .stack_i (stack_q),
      .d_i     ((i == 0) ? div_in : div_c[(i == 0) ? 0 : i - 1]),
      .q_o     (div_c[i])
    );
  end

  always_comb begin
    usvg_pkg::div_t d;
    d = div_c[usvg_pkg::DIV_STEPS-1];
    cord_in        = '0;
    cord_in.valid  = d.valid;
    cord_in.meta   = d.meta;
    cord_in.quad_t = d.q_t[31:30];
    cord_in.quad_p = d.q_p[31:30];
    cord_in.x_t    = usvg_pkg::GAIN_Q30;
    cord_in.x_p    = usvg_pkg::GAIN_Q30;
    cord_in.z_t    = $signed({3'b000, d.q_t[29:0]});
    cord_in.z_p    = $signed({3'b000, d.q_p[29:0]});
    cord_in.tex_u  = d.q_u;
    cord_in.tex_v  = d.q_v;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cord
    usvg_cordic_cell #(.STEP(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .d_i    ((i == 0) ? cord_in : cord_c[(i == 0) ? 0 : i - 1]),
      .q_o    (cord_c[i])
    );
  end

  usvg_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .d_i     (cord_c[CORDIC_STEPS-1]),
    .valid_o (m_axis_tvalid),
    .data_o  (m_axis_tdata)
  );

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[145] |-> m_axis_tdata[144:0] == '0)
    else $error("out-of-range vertex carries nonzero fields");

  a_quad_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[144] && m_axis_tdata[145]))
    else $error("quad corner flagged on an out-of-range vertex");

  a_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[145] && !cfg_we_i |->
      m_axis_tdata[143:127] ==
        17'(m_axis_tdata[126:110] + 17'(slice_q) + 17'd1))
    else $error("below index does not follow vertex index");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule
